// ===== rtl/bfra_pkg.sv =====
// shared constants, types and codes for the best-fit region allocator
// used by every module under rtl
package bfra_pkg;

    localparam int unsigned MAX_REGIONS  = 64;
    localparam int unsigned MAX_CAPACITY = 1048576;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned REQ_W  = 21;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned POS_W  = 20;
    localparam int unsigned FIT_W  = 22;
    localparam int unsigned FIN_W  = 7;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned ST_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_ADVANCE = 3'd2,
        OP_COMPACT = 3'd3,
        OP_FITQ    = 3'd4,
        OP_IDQ     = 3'd5,
        OP_NOP6    = 3'd6,
        OP_NOP7    = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_ID_EXIST = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_GAP,
        S_WALK,
        S_WALK_RD,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== rtl/best_fit_region_allocator.sv =====
// top level of the best-fit region allocator: sequencer, shared compare/add unit
// depends on bfra_pkg and bfra_table
//
// channel  direction  handshake      payload
// in       input      valid / stall  op, proc_id, request_size, run_time, time_step
// out      output     valid / stall  status, position, fit_size, id_present,
//                                    finished_count, free_total, any_active
// cfg      input      valid / ready  capacity
//
// every op starts with a pass over all MAX_REGIONS slots (one read a cycle) that
// checks ids, finds a free slot and applies time advance. allocate, compact and
// the best-fit query then walk the regions in address order: each step picks the
// next-lowest start with one more pass, so their run time grows with the number
// of live regions; the others end after the first pass.
// a capacity write or reset runs no clearing pass; valid bits clear at once.
// in_stall is high from acceptance until the result is transferred; the result
// register holds under out_stall.
module best_fit_region_allocator #(
    parameter int unsigned MAX_REGIONS  = bfra_pkg::MAX_REGIONS,
    parameter int unsigned MAX_CAPACITY = bfra_pkg::MAX_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [15:0] proc_id,
    input  logic [20:0] request_size,
    input  logic [31:0] run_time,
    input  logic [31:0] time_step,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [19:0] position,
    output logic signed [21:0] fit_size,
    output logic        id_present,
    output logic [6:0]  finished_count,
    output logic [20:0] free_total,
    output logic        any_active,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);

    localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CW = AW + 1;
    localparam int unsigned PW = bfra_pkg::POS_W;
    localparam int unsigned LW = bfra_pkg::REQ_W;
    localparam int unsigned TW = bfra_pkg::TIME_W;
    localparam int unsigned FIN_W_L = bfra_pkg::FIN_W;
    localparam logic [LW-1:0] CAP_MAX = LW'(MAX_CAPACITY > 1048576 ? 1048576 : MAX_CAPACITY);

    bfra_pkg::state_t state_reg, state_next;

    // latched item
    bfra_pkg::op_t     op_reg;
    logic [15:0]       id_reg;
    logic [LW-1:0]     req_reg;
    logic [TW-1:0]     rt_reg, ts_reg;

    logic [LW-1:0]     cap_reg, free_reg, free_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     rd_addr;

    // scan results
    logic              found_id_reg, found_id_next;
    logic [AW-1:0]     id_slot_reg, id_slot_next;
    logic [LW-1:0]     id_len_reg, id_len_next;
    logic              have_free_reg, have_free_next;
    logic [AW-1:0]     free_slot_reg, free_slot_next;
    logic [FIN_W_L-1:0] fin_reg, fin_next;

    // address-order walk: cursor = end of the previous region, last = its start
    logic [LW-1:0]     cursor_reg, cursor_next;
    logic [LW-1:0]     pos_reg, pos_next;
    logic              have_last_reg, have_last_next;
    logic [PW-1:0]     last_start_reg, last_start_next;
    logic              cand_reg, cand_next;
    logic [PW-1:0]     cand_start_reg, cand_start_next;
    logic [LW-1:0]     cand_len_reg, cand_len_next;
    logic [AW-1:0]     cand_slot_reg, cand_slot_next;
    logic              best_reg, best_next;
    logic [LW-1:0]     best_size_reg, best_size_next;
    logic [PW-1:0]     best_start_reg, best_start_next;

    // compact rewrites need the candidate's id and time: the walk ends with its
    // read address wrapped to slot 0, so the write uses the captured fields
    logic [15:0]       cand_ident_reg;
    logic [TW-1:0]     cand_time_reg;

    // result
    logic [2:0]        res_status_reg, res_status_next;
    logic [19:0]       res_pos_reg, res_pos_next;
    logic [21:0]       res_fit_reg, res_fit_next;
    logic              res_idp_reg, res_idp_next;
    logic [6:0]        res_fin_reg, res_fin_next;
    logic              out_valid_reg;

    // table port
    logic              t_rd_valid;
    logic [15:0]       t_ident;
    logic [PW-1:0]     t_start;
    logic [LW-1:0]     t_length;
    logic [TW-1:0]     t_time;
    logic              wr_en, wr_v, clear_all, t_any;
    logic [AW-1:0]     wr_addr;
    logic [15:0]       wr_ident;
    logic [PW-1:0]     wr_start;
    logic [LW-1:0]     wr_length;
    logic [TW-1:0]     wr_time;

    logic              in_xfer, out_xfer, cfg_xfer;
    logic [AW-1:0]     prev_idx;
    logic              data_ok;
    logic [LW-1:0]     gap_end, gap;
    logic              gap_fit;
    logic [LW-1:0]     cfg_clamped;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    // no capacity write while a result waits, free_total must hold
    assign cfg_ready = (state_reg == bfra_pkg::S_IDLE) && !out_valid_reg;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign in_stall = (state_reg != bfra_pkg::S_IDLE) || out_valid_reg;
    assign clear_all = cfg_xfer;

    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = LW'(1);
        else if (cfg_data > CAP_MAX)
            cfg_clamped = CAP_MAX;
        else
            cfg_clamped = cfg_data;
    end

    assign rd_addr  = idx_reg[AW-1:0];
    assign prev_idx = AW'(idx_reg - CW'(1));
    // read data belongs to address idx_reg-1 while 1 <= idx_reg <= MAX_REGIONS
    assign data_ok  = (idx_reg != '0) && t_rd_valid;

    bfra_table #(.NREG(MAX_REGIONS), .AW(AW), .PW(PW), .LW(LW)) u_table (
        .clk(clk), .rst_n(rst_n), .clear_all(clear_all), .rd_addr(rd_addr),
        .rd_valid(t_rd_valid), .rd_ident(t_ident), .rd_start(t_start),
        .rd_length(t_length), .rd_time(t_time), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_valid(wr_v), .wr_ident(wr_ident), .wr_start(wr_start),
        .wr_length(wr_length), .wr_time(wr_time), .any_valid(t_any)
    );

    // shared gap unit: hole between cursor and gap_end
    always_comb
    begin
        gap_end = cand_reg ? LW'(cand_start_reg) : cap_reg;
        gap     = gap_end - cursor_reg;
        gap_fit = (gap_end > cursor_reg) && (gap >= req_reg) &&
                  (!best_reg || gap < best_size_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfra_pkg::S_IDLE:
                if (in_xfer)
                    state_next = bfra_pkg::S_SCAN;
            bfra_pkg::S_SCAN:
                if (idx_reg == CW'(MAX_REGIONS))
                begin
                    if (op_reg == bfra_pkg::OP_ALLOC && !found_id_next && have_free_next
                        && req_reg != '0)
                        state_next = bfra_pkg::S_WALK;
                    else if (op_reg == bfra_pkg::OP_FITQ && req_reg != '0)
                        state_next = bfra_pkg::S_WALK;
                    else if (op_reg == bfra_pkg::OP_COMPACT)
                        state_next = bfra_pkg::S_WALK;
                    else
                        state_next = bfra_pkg::S_DONE;
                end
            bfra_pkg::S_WALK:
                if (idx_reg == CW'(MAX_REGIONS))
                    state_next = bfra_pkg::S_GAP;
            bfra_pkg::S_GAP:
                if (!cand_reg || op_reg == bfra_pkg::OP_COMPACT)
                    state_next = (!cand_reg) ?
                        ((op_reg == bfra_pkg::OP_ALLOC && (best_reg || gap_fit)) ?
                            bfra_pkg::S_WRITE : bfra_pkg::S_DONE) : bfra_pkg::S_WALK;
                else
                    state_next = bfra_pkg::S_WALK;
            bfra_pkg::S_WRITE:
                state_next = bfra_pkg::S_DONE;
            bfra_pkg::S_DONE:
                state_next = bfra_pkg::S_IDLE;
            default:
                state_next = bfra_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next        = idx_reg;
        found_id_next   = found_id_reg;
        id_slot_next    = id_slot_reg;
        id_len_next     = id_len_reg;
        have_free_next  = have_free_reg;
        free_slot_next  = free_slot_reg;
        fin_next        = fin_reg;
        free_next       = free_reg;
        cursor_next     = cursor_reg;
        pos_next        = pos_reg;
        have_last_next  = have_last_reg;
        last_start_next = last_start_reg;
        cand_next       = cand_reg;
        cand_start_next = cand_start_reg;
        cand_len_next   = cand_len_reg;
        cand_slot_next  = cand_slot_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_fit_next    = res_fit_reg;
        res_idp_next    = res_idp_reg;
        res_fin_next    = res_fin_reg;
        wr_en     = 1'b0;
        wr_addr   = prev_idx;
        wr_v      = 1'b1;
        wr_ident  = t_ident;
        wr_start  = t_start;
        wr_length = t_length;
        wr_time   = t_time;

        case (state_reg)
            bfra_pkg::S_IDLE:
            begin
                idx_next       = '0;
                found_id_next  = 1'b0;
                have_free_next = 1'b0;
                fin_next       = '0;
                if (cfg_xfer)
                    free_next = cfg_clamped;
            end
            bfra_pkg::S_SCAN:
            begin
                if (idx_reg != '0)
                begin
                    if (!t_rd_valid && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_slot_next = prev_idx;
                    end
                    if (data_ok && t_ident == id_reg && !found_id_reg)
                    begin
                        found_id_next = 1'b1;
                        id_slot_next  = prev_idx;
                        id_len_next   = t_length;
                    end
                    if (data_ok && op_reg == bfra_pkg::OP_ADVANCE)
                    begin
                        wr_en = 1'b1;
                        if (t_time <= ts_reg)
                        begin
                            wr_v      = 1'b0;
                            free_next = free_reg + t_length;
                            fin_next  = fin_reg + FIN_W_L'(1);
                        end
                        else
                            wr_time = t_time - ts_reg;
                    end
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MAX_REGIONS))
                begin
                    idx_next        = '0;
                    res_status_next = bfra_pkg::ST_OK;
                    res_pos_next    = '0;
                    res_fit_next    = '0;
                    res_idp_next    = 1'b0;
                    res_fin_next    = 7'(fin_next);
                    cursor_next     = '0;
                    pos_next        = '0;
                    have_last_next  = 1'b0;
                    cand_next       = 1'b0;
                    best_next       = 1'b0;
                    case (op_reg)
                        bfra_pkg::OP_ALLOC:
                            if (found_id_next)
                                res_status_next = bfra_pkg::ST_ID_EXIST;
                            else if (!have_free_next)
                                res_status_next = bfra_pkg::ST_FULL;
                            else if (req_reg == '0)
                                res_status_next = bfra_pkg::ST_NO_FIT;
                        bfra_pkg::OP_RELEASE:
                            if (!found_id_next)
                                res_status_next = bfra_pkg::ST_NOT_FOUND;
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = id_slot_next;
                                wr_v      = 1'b0;
                                free_next = free_reg + id_len_next;
                            end
                        bfra_pkg::OP_FITQ:
                            if (req_reg == '0)
                                res_fit_next = '1;
                        bfra_pkg::OP_IDQ:
                            res_idp_next = found_id_next;
                        default:
                            res_status_next = bfra_pkg::ST_OK;
                    endcase
                end
            end
            bfra_pkg::S_WALK:
            begin
                // pick the smallest start strictly above the last one
                if (data_ok && (!have_last_reg || t_start > last_start_reg) &&
                    (!cand_reg || t_start < cand_start_reg))
                begin
                    cand_next       = 1'b1;
                    cand_start_next = t_start;
                    cand_len_next   = t_length;
                    cand_slot_next  = prev_idx;
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MAX_REGIONS))
                    idx_next = '0;
            end
            bfra_pkg::S_GAP:
            begin
                if (op_reg == bfra_pkg::OP_COMPACT)
                begin
                    if (cand_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = cand_slot_reg;
                        wr_ident  = cand_ident_reg;
                        wr_start  = PW'(pos_reg);
                        wr_length = cand_len_reg;
                        wr_time   = cand_time_reg;
                        pos_next  = pos_reg + cand_len_reg;
                    end
                end
                else if (gap_fit)
                begin
                    best_next       = 1'b1;
                    best_size_next  = gap;
                    best_start_next = PW'(cursor_reg);
                end
                if (cand_reg)
                begin
                    cursor_next     = LW'(cand_start_reg) + cand_len_reg;
                    have_last_next  = 1'b1;
                    last_start_next = cand_start_reg;
                end
                cand_next = 1'b0;
                if (!cand_reg && op_reg != bfra_pkg::OP_COMPACT)
                begin
                    if (op_reg == bfra_pkg::OP_FITQ)
                        res_fit_next = (best_reg || gap_fit) ?
                            22'(gap_fit ? gap : best_size_reg) : '1;
                    else if (!(best_reg || gap_fit))
                        res_status_next = bfra_pkg::ST_NO_FIT;
                end
            end
            bfra_pkg::S_WRITE:
            begin
                wr_en        = 1'b1;
                wr_addr      = free_slot_reg;
                wr_ident     = id_reg;
                wr_start     = best_start_reg;
                wr_length    = req_reg;
                wr_time      = rt_reg;
                free_next    = free_reg - req_reg;
                res_pos_next = best_start_reg;
            end
            default:
                idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfra_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_MAX;
            free_reg      <= CAP_MAX;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            free_reg  <= free_next;
            if (cfg_xfer)
                cap_reg <= cfg_clamped;
            if (state_reg == bfra_pkg::S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= bfra_pkg::op_t'(op);
            id_reg  <= proc_id;
            req_reg <= request_size;
            rt_reg  <= run_time;
            ts_reg  <= time_step;
        end
        found_id_reg   <= found_id_next;
        id_slot_reg    <= id_slot_next;
        id_len_reg     <= id_len_next;
        have_free_reg  <= have_free_next;
        free_slot_reg  <= free_slot_next;
        fin_reg        <= fin_next;
        cursor_reg     <= cursor_next;
        pos_reg        <= pos_next;
        have_last_reg  <= have_last_next;
        last_start_reg <= last_start_next;
        cand_reg       <= cand_next;
        cand_start_reg <= cand_start_next;
        cand_len_reg   <= cand_len_next;
        cand_slot_reg  <= cand_slot_next;
        best_reg       <= best_next;
        best_size_reg  <= best_size_next;
        best_start_reg <= best_start_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_fit_reg    <= res_fit_next;
        res_idp_reg    <= res_idp_next;
        res_fin_reg    <= res_fin_next;
        if (state_reg == bfra_pkg::S_WALK && data_ok &&
            (!have_last_reg || t_start > last_start_reg) &&
            (!cand_reg || t_start < cand_start_reg))
        begin
            cand_ident_reg <= t_ident;
            cand_time_reg  <= t_time;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_status_reg;
    assign position       = res_pos_reg;
    assign fit_size       = res_fit_reg;
    assign id_present     = res_idp_reg;
    assign finished_count = res_fin_reg;
    assign free_total     = free_reg;
    assign any_active     = t_any;

endmodule

// ===== rtl/bfra_table.sv =====
// region table storage: valid bits plus per-slot id, start, length, time memories
// depends on bfra_pkg
module bfra_table #(
    parameter int unsigned NREG = bfra_pkg::MAX_REGIONS,
    parameter int unsigned AW   = $clog2(NREG),
    parameter int unsigned PW   = bfra_pkg::POS_W,
    parameter int unsigned LW   = bfra_pkg::REQ_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear_all,
    input  logic [AW-1:0]               rd_addr,
    output logic                        rd_valid,
    output logic [bfra_pkg::ID_W-1:0]   rd_ident,
    output logic [PW-1:0]               rd_start,
    output logic [LW-1:0]               rd_length,
    output logic [bfra_pkg::TIME_W-1:0] rd_time,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic                        wr_valid,
    input  logic [bfra_pkg::ID_W-1:0]   wr_ident,
    input  logic [PW-1:0]               wr_start,
    input  logic [LW-1:0]               wr_length,
    input  logic [bfra_pkg::TIME_W-1:0] wr_time,
    output logic                        any_valid
);

    logic [NREG-1:0]             valid_reg;
    logic [bfra_pkg::ID_W-1:0]   ident_mem [NREG];
    logic [PW-1:0]               start_mem [NREG];
    logic [LW-1:0]               length_mem [NREG];
    logic [bfra_pkg::TIME_W-1:0] time_mem [NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            if (clear_all)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= wr_valid;
            rd_valid <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ident_mem[wr_addr]  <= wr_ident;
            start_mem[wr_addr]  <= wr_start;
            length_mem[wr_addr] <= wr_length;
            time_mem[wr_addr]   <= wr_time;
        end
        rd_ident  <= ident_mem[rd_addr];
        rd_start  <= start_mem[rd_addr];
        rd_length <= length_mem[rd_addr];
        rd_time   <= time_mem[rd_addr];
    end

    assign any_valid = |valid_reg;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for best_fit_region_allocator
// depends on rtl/bfra_pkg.sv, rtl/bfra_table.sv and rtl/best_fit_region_allocator.sv
// keeps its own copy of the region table, predicts every result and compares field by field
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] position;
        logic [21:0] fit_size;
        logic        id_present;
        logic [6:0]  finished_count;
        logic [20:0] free_total;
        logic        any_active;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [15:0] proc_id;
    logic [20:0] request_size;
    logic [31:0] run_time;
    logic [31:0] time_step;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [19:0] position;
    logic signed [21:0] fit_size;
    logic        id_present;
    logic [6:0]  finished_count;
    logic [20:0] free_total;
    logic        any_active;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [20:0] cfg_data;

    best_fit_region_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .proc_id       (proc_id),
        .request_size  (request_size),
        .run_time      (run_time),
        .time_step     (time_step),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .position      (position),
        .fit_size      (fit_size),
        .id_present    (id_present),
        .finished_count(finished_count),
        .free_total    (free_total),
        .any_active    (any_active),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // predicted region table
    bit          rg_valid [bfra_pkg::MAX_REGIONS];
    logic [15:0] rg_ident [bfra_pkg::MAX_REGIONS];
    int unsigned rg_start [bfra_pkg::MAX_REGIONS];
    int unsigned rg_len   [bfra_pkg::MAX_REGIONS];
    logic [31:0] rg_time  [bfra_pkg::MAX_REGIONS];
    int unsigned mem_capacity;
    int unsigned mem_free;

    alloc_result_t expected_results[$];
    int unsigned   error_count;
    int unsigned   cycle_count;
    bit            no_idle;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void clear_regions();
        foreach (rg_valid[i]) rg_valid[i] = 1'b0;
        mem_free = mem_capacity;
    endfunction

    function automatic int find_region(logic [15:0] id);
        for (int i = 0; i < bfra_pkg::MAX_REGIONS; i++)
            if (rg_valid[i] && rg_ident[i] == id) return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        foreach (rg_valid[i]) if (rg_valid[i]) n++;
        return n;
    endfunction

    // live slot indices ordered by start address
    function automatic void address_order(ref int ord[$]);
        int j;
        ord.delete();
        for (int i = 0; i < bfra_pkg::MAX_REGIONS; i++)
        begin
            if (!rg_valid[i]) continue;
            j = ord.size();
            while (j > 0 && rg_start[ord[j-1]] > rg_start[i]) j--;
            ord.insert(j, i);
        end
    endfunction

    // smallest hole that holds want units, lowest start on ties
    function automatic bit find_best_hole(int unsigned want, output int unsigned hstart,
                                          output int unsigned hsize);
        int ord[$];
        int unsigned cursor;
        int unsigned hole_end;
        bit found;
        found = 1'b0;
        cursor = 0;
        hstart = 0;
        hsize = 0;
        if (want == 0) return 1'b0;
        address_order(ord);
        for (int k = 0; k <= ord.size(); k++)
        begin
            hole_end = (k < ord.size()) ? rg_start[ord[k]] : mem_capacity;
            if (hole_end > cursor && hole_end - cursor >= want
                && (!found || hole_end - cursor < hsize))
            begin
                found = 1'b1;
                hsize = hole_end - cursor;
                hstart = cursor;
            end
            if (k < ord.size()) cursor = rg_start[ord[k]] + rg_len[ord[k]];
        end
        return found;
    endfunction

    function automatic alloc_result_t apply_op(bfra_pkg::op_t code, logic [15:0] id,
                                               logic [20:0] req,
                                               logic [31:0] rt, logic [31:0] ts);
        alloc_result_t r;
        int slot;
        int hit;
        int ord[$];
        int unsigned hs;
        int unsigned hz;
        int unsigned pos;
        r = '0;
        r.status = bfra_pkg::ST_OK;
        case (code)
            bfra_pkg::OP_ALLOC:
            begin
                slot = -1;
                for (int i = 0; i < bfra_pkg::MAX_REGIONS; i++)
                    if (!rg_valid[i]) begin slot = i; break; end
                if (find_region(id) >= 0) r.status = bfra_pkg::ST_ID_EXIST;
                else if (slot < 0) r.status = bfra_pkg::ST_FULL;
                else if (!find_best_hole(req, hs, hz)) r.status = bfra_pkg::ST_NO_FIT;
                else
                begin
                    rg_valid[slot] = 1'b1;
                    rg_ident[slot] = id;
                    rg_start[slot] = hs;
                    rg_len[slot] = req;
                    rg_time[slot] = rt;
                    mem_free -= req;
                    r.position = 20'(hs);
                end
            end
            bfra_pkg::OP_RELEASE:
            begin
                hit = find_region(id);
                if (hit < 0) r.status = bfra_pkg::ST_NOT_FOUND;
                else
                begin
                    rg_valid[hit] = 1'b0;
                    mem_free += rg_len[hit];
                end
            end
            bfra_pkg::OP_ADVANCE:
            begin
                for (int i = 0; i < bfra_pkg::MAX_REGIONS; i++)
                begin
                    if (!rg_valid[i]) continue;
                    if (rg_time[i] <= ts)
                    begin
                        rg_valid[i] = 1'b0;
                        mem_free += rg_len[i];
                        r.finished_count++;
                    end
                    else rg_time[i] -= ts;
                end
            end
            bfra_pkg::OP_COMPACT:
            begin
                address_order(ord);
                pos = 0;
                foreach (ord[k])
                begin
                    rg_start[ord[k]] = pos;
                    pos += rg_len[ord[k]];
                end
            end
            bfra_pkg::OP_FITQ:
                r.fit_size = find_best_hole(req, hs, hz) ? 22'(hz) : '1;
            bfra_pkg::OP_IDQ:
                r.id_present = (find_region(id) >= 0);
            default: ;
        endcase
        r.free_total = 21'(mem_free);
        r.any_active = (live_count() != 0);
        return r;
    endfunction

    // result side: random stall per transfer, compare against oldest expectation
    int unsigned stall_left;
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    error_count++;
                end
                if (position !== e.position)
                begin
                    $error("position expected %0d actual %0d", e.position, position);
                    error_count++;
                end
                if (fit_size !== e.fit_size)
                begin
                    $error("fit_size expected %0d actual %0d", $signed(e.fit_size), fit_size);
                    error_count++;
                end
                if (id_present !== e.id_present)
                begin
                    $error("id_present expected %0d actual %0d", e.id_present, id_present);
                    error_count++;
                end
                if (finished_count !== e.finished_count)
                begin
                    $error("finished_count expected %0d actual %0d", e.finished_count,
                           finished_count);
                    error_count++;
                end
                if (free_total !== e.free_total)
                begin
                    $error("free_total expected %0d actual %0d", e.free_total, free_total);
                    error_count++;
                end
                if (any_active !== e.any_active)
                begin
                    $error("any_active expected %0d actual %0d", e.any_active, any_active);
                    error_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
        end
        else if (stall_left != 0) stall_left--;
        out_stall <= (stall_left != 0);
    end

    task automatic send_op(bfra_pkg::op_t code, logic [15:0] id, logic [20:0] req,
                           logic [31:0] rt, logic [31:0] ts);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= code;
        proc_id <= id;
        request_size <= req;
        run_time <= rt;
        time_step <= ts;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(apply_op(code, id, req, rt, ts));
    endtask

    // sender holds off until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_capacity(logic [20:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mem_capacity = (value == 0) ? 1 :
                       (value > bfra_pkg::MAX_CAPACITY) ? bfra_pkg::MAX_CAPACITY : value;
        clear_regions();
    endtask

    task automatic test_extremes();
        write_capacity(21'd1048576);
        send_op(bfra_pkg::OP_ALLOC, 16'd0, 21'd1, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ADVANCE, 16'd0, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'hFFFF, 21'd1048576, 32'hFFFFFFFF, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'hFFFF, 21'd1, 32'd5, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd7, 21'd1, 32'd5, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd1, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_IDQ, 16'hFFFF, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_IDQ, 16'd3, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_RELEASE, 16'd3, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ADVANCE, 16'd0, 21'd0, 32'd0, 32'hFFFFFFFE);
        send_op(bfra_pkg::OP_RELEASE, 16'hFFFF, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd1, 21'd0, 32'd9, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd1, 21'h1FFFFF, 32'd9, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd1048576, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_NOP6, 16'hFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(bfra_pkg::OP_NOP7, 16'd0, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_COMPACT, 16'd0, 21'd0, 32'd0, 32'd0);
    endtask

    // holes, ties, merging on release, compaction
    task automatic test_holes();
        write_capacity(21'd100);
        send_op(bfra_pkg::OP_ALLOC, 16'd1, 21'd10, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd2, 21'd20, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd3, 21'd10, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd4, 21'd20, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd5, 21'd10, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_RELEASE, 16'd2, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_RELEASE, 16'd4, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd15, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd6, 21'd15, 32'd50, 32'd0);
        send_op(bfra_pkg::OP_RELEASE, 16'd3, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd25, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_COMPACT, 16'd0, 21'd0, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_FITQ, 16'd0, 21'd1, 32'd0, 32'd0);
        send_op(bfra_pkg::OP_ADVANCE, 16'd0, 21'd0, 32'd0, 32'd50);
    endtask

    task automatic test_full_table();
        write_capacity(21'd1000);
        no_idle = 1'b1;
        for (int i = 0; i <= bfra_pkg::MAX_REGIONS; i++)
            send_op(bfra_pkg::OP_ALLOC, 16'(i + 100), 21'd3, 32'd1, 32'd0);
        send_op(bfra_pkg::OP_ALLOC, 16'd100, 21'd3, 32'd1, 32'd0);
        send_op(bfra_pkg::OP_ADVANCE, 16'd0, 21'd0, 32'd0, 32'd1);
        no_idle = 1'b0;
    endtask

    function automatic logic [20:0] pick_size();
        int unsigned c;
        c = $urandom_range(0, 19);
        if (c == 0) return 21'd0;
        if (c == 1) return 21'($urandom);
        if (c == 2) return 21'(mem_capacity);
        if (c < 6) return 21'($urandom_range(1, mem_capacity));
        return 21'($urandom_range(1, mem_capacity / 6 + 1));
    endfunction

    function automatic logic [15:0] pick_id();
        int ord[$];
        int unsigned c;
        c = $urandom_range(0, 9);
        address_order(ord);
        if (c < 4 && ord.size() != 0) return rg_ident[ord[$urandom_range(0, ord.size() - 1)]];
        if (c < 8) return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    task automatic random_phase(logic [20:0] cap_value, int items);
        bfra_pkg::op_t code;
        int unsigned c;
        logic [31:0] rt;
        write_capacity(cap_value);
        for (int n = 0; n < items; n++)
        begin
            if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            c = $urandom_range(0, 99);
            // keep the table small so most ops stay short
            if (live_count() >= 8 && c < 45) c = c + 45;
            if (c < 45) code = bfra_pkg::OP_ALLOC;
            else if (c < 62) code = bfra_pkg::OP_RELEASE;
            else if (c < 72) code = bfra_pkg::OP_ADVANCE;
            else if (c < 78) code = bfra_pkg::OP_COMPACT;
            else if (c < 88) code = bfra_pkg::OP_FITQ;
            else if (c < 96) code = bfra_pkg::OP_IDQ;
            else code = (c < 98) ? bfra_pkg::OP_NOP6 : bfra_pkg::OP_NOP7;
            rt = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 40));
            send_op(code, pick_id(), pick_size(), rt,
                    ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 12)));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        random_phase(21'h1FFFFF, 200);
        random_phase(21'd0, 60);
        random_phase(21'd7, 160);
        random_phase(21'd100, 250);
        random_phase(21'd1000, 250);
        random_phase(21'($urandom_range(16, 5000)), 240);
        random_phase(21'd1048576, 240);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= bfra_pkg::OP_NOP6;
        proc_id <= '0;
        request_size <= '0;
        run_time <= '0;
        time_step <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        no_idle = 1'b0;
        mem_capacity = bfra_pkg::MAX_CAPACITY;
        clear_regions();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_holes();
        test_full_table();
        test_random();

        drain();
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
